// ===== rtl/rvex_pkg.sv =====
// Shared types, codes and helpers for the RV64IM execute core.
package rvex_pkg;

    localparam int XLEN = 64;

    typedef enum logic [5:0] {
        F_LUI    = 6'd0,  F_AUIPC = 6'd1,  F_JAL   = 6'd2,  F_JALR  = 6'd3,
        F_BEQ    = 6'd4,  F_BNE   = 6'd5,  F_BLT   = 6'd6,  F_BGE   = 6'd7,
        F_BLTU   = 6'd8,  F_BGEU  = 6'd9,
        F_ADDI   = 6'd10, F_SLTI  = 6'd11, F_SLTIU = 6'd12, F_XORI  = 6'd13,
        F_ORI    = 6'd14, F_ANDI  = 6'd15, F_SLLI  = 6'd16, F_SRLI  = 6'd17,
        F_SRAI   = 6'd18,
        F_ADD    = 6'd19, F_SUB   = 6'd20, F_SLL   = 6'd21, F_SLT   = 6'd22,
        F_SLTU   = 6'd23, F_XOR   = 6'd24, F_SRL   = 6'd25, F_SRA   = 6'd26,
        F_OR     = 6'd27, F_AND   = 6'd28,
        F_ADDIW  = 6'd29, F_SLLIW = 6'd30, F_SRLIW = 6'd31, F_SRAIW = 6'd32,
        F_ADDW   = 6'd33, F_SUBW  = 6'd34, F_SLLW  = 6'd35, F_SRLW  = 6'd36,
        F_SRAW   = 6'd37,
        F_MUL    = 6'd38, F_MULH  = 6'd39, F_MULHSU = 6'd40, F_MULHU = 6'd41,
        F_DIV    = 6'd42, F_DIVU  = 6'd43, F_REM   = 6'd44, F_REMU  = 6'd45,
        F_MULW   = 6'd46, F_DIVW  = 6'd47, F_DIVUW = 6'd48, F_REMW  = 6'd49,
        F_REMUW  = 6'd50
    } t_func;

    // how the finish stage builds the destination value
    typedef enum logic [2:0] {
        K_ALU, K_MUL, K_MULW, K_MULH, K_DIVQ, K_DIVR
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             word;
        logic             neg;
        logic             rd_write;
        logic             redirect;
        logic [XLEN-1:0]  target;
        logic [4:0]       dest;
    } t_ctl;

    // front -> product combine
    typedef struct packed {
        t_ctl             ctl;
        logic [XLEN-1:0]  p00;
        logic [XLEN-1:0]  p01;
        logic [XLEN-1:0]  p10;
        logic [XLEN-1:0]  p11;
        logic [XLEN-1:0]  aux;
        logic [XLEN-1:0]  quo;
        logic [XLEN-1:0]  dvs;
    } t_front;

    // item moving along the divider cells
    typedef struct packed {
        t_ctl             ctl;
        logic [XLEN-1:0]  rem;
        logic [XLEN-1:0]  quo;
        logic [XLEN-1:0]  dvs;
        logic [XLEN-1:0]  aux;
    } t_cell;

    function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

endpackage

// ===== rtl/rv64im_integer_execute_core.sv =====
// Top level of the RV64IM integer execute core.
// Every operation passes through every stage on its way from input transfer to result.
// Throughput: one instruction per cycle while the output is not stalled; the 64 divider cells each hold one item.
// Each stage loads whenever it is empty or its successor moves, so bubbles close up
// behind a stalled output.
// Reset (synchronous, active low) empties every stage; payload registers are not reset.
module rv64im_integer_execute_core
    import rvex_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [5:0]          i_func,
    input  logic [XLEN-1:0]     i_src1_value,
    input  logic [XLEN-1:0]     i_src2_value,
    input  logic signed [31:0]  i_immediate,
    input  logic [XLEN-1:0]     i_pc_value,
    input  logic [4:0]          i_dest_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [XLEN-1:0]     o_rd_value,
    output logic                o_rd_write,
    output logic [4:0]          o_dest_out,
    output logic                o_redirect,
    output logic [XLEN-1:0]     o_redirect_target
);

    // Stage map: front, product sum, XLEN divider cells, finish.
    // Non-divide items ride through the cells untouched so order is kept.

    logic   front_valid, front_ready;
    t_front front_item;

    // cell chain: index 0 is the product-sum output, index k the k-th cell's
    logic  c_valid [XLEN+1];
    logic  c_ready [XLEN+1];
    t_cell c_item  [XLEN+1];
    logic  fin_ready;

    rvex_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_func       (i_func),
        .i_src1_value (i_src1_value),
        .i_src2_value (i_src2_value),
        .i_immediate  (i_immediate),
        .i_pc_value   (i_pc_value),
        .i_dest_index (i_dest_index),
        .i_ready      (c_ready[0]),
        .o_ready      (front_ready),
        .o_valid      (front_valid),
        .o_item       (front_item)
    );

    // input transfer happens when the front stage can load
    assign o_stall = !front_ready;

    rvex_mulsum u_mulsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .i_ready (c_ready[1]),
        .o_ready (c_ready[0]),
        .o_valid (c_valid[0]),
        .o_item  (c_item[0])
    );

    for (genvar k = 1; k <= XLEN; k++) begin : g_cell
        logic nxt_ready;
        if (k == XLEN) begin : g_last
            assign nxt_ready = fin_ready;
        end else begin : g_mid
            assign nxt_ready = c_ready[k+1];
        end
        rvex_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k-1]),
            .i_item  (c_item[k-1]),
            .i_ready (nxt_ready),
            .o_ready (c_ready[k]),
            .o_valid (c_valid[k]),
            .o_item  (c_item[k])
        );
    end

    rvex_finish u_finish (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (c_valid[XLEN]),
        .i_item            (c_item[XLEN]),
        .i_stall           (i_stall),
        .o_ready           (fin_ready),
        .o_valid           (o_valid),
        .o_rd_value        (o_rd_value),
        .o_rd_write        (o_rd_write),
        .o_dest_out        (o_dest_out),
        .o_redirect        (o_redirect),
        .o_redirect_target (o_redirect_target)
    );

`ifndef SYNTHESIS
    // the input only backs up when every stage is full and the output is held
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // branches and unknown codes leave the destination value at zero
    a_nowrite_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rd_write) |-> (o_rd_value == '0))
        else $error("non-zero value without a write");

    // target is zero unless a redirect is flagged
    a_target_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_redirect) |-> (o_redirect_target == '0))
        else $error("target set without redirect");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule

// ===== rtl/rvex_front.sv =====
// Decode, combinational ALU, branch resolve, partial products and divide set-up.
module rvex_front
    import rvex_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [5:0]          i_func,
    input  logic [XLEN-1:0]     i_src1_value,
    input  logic [XLEN-1:0]     i_src2_value,
    input  logic signed [31:0]  i_immediate,
    input  logic [XLEN-1:0]     i_pc_value,
    input  logic [4:0]          i_dest_index,
    input  logic                i_ready,
    output logic                o_ready,
    output logic                o_valid,
    output t_front              o_item
);

    logic            r_valid;
    t_front          r_item;
    t_front          n_item;

    logic [XLEN-1:0] a, b, imm64, pc_imm;
    logic [5:0]      sh_i, sh_r;
    logic [4:0]      shw_i, shw_r;

    assign a      = i_src1_value;
    assign b      = i_src2_value;
    assign imm64  = {{32{i_immediate[31]}}, i_immediate};
    assign pc_imm = i_pc_value + imm64;
    assign sh_i   = imm64[5:0];
    assign sh_r   = b[5:0];
    assign shw_i  = imm64[4:0];
    assign shw_r  = b[4:0];

    always_comb begin
        logic            d_op, d_sgn, d_word, d_rem, dz, na, nb;
        logic [XLEN-1:0] sa, sb;
        logic [31:0]     wsra;

        d_op   = 1'b0;
        d_sgn  = 1'b0;
        d_word = 1'b0;
        d_rem  = 1'b0;
        wsra   = '0;

        n_item              = '0;
        n_item.ctl.kind     = K_ALU;
        n_item.ctl.rd_write = 1'b1;
        n_item.ctl.dest     = i_dest_index;
        n_item.p00 = {32'b0, a[31:0]}  * {32'b0, b[31:0]};
        n_item.p01 = {32'b0, a[31:0]}  * {32'b0, b[63:32]};
        n_item.p10 = {32'b0, a[63:32]} * {32'b0, b[31:0]};
        n_item.p11 = {32'b0, a[63:32]} * {32'b0, b[63:32]};

        case (t_func'(i_func))
            F_LUI:   n_item.aux = imm64;
            F_AUIPC: n_item.aux = pc_imm;
            F_JAL: begin
                n_item.aux          = i_pc_value + 64'd4;
                n_item.ctl.redirect = 1'b1;
                n_item.ctl.target   = pc_imm;
            end
            F_JALR: begin
                n_item.aux          = i_pc_value + 64'd4;
                n_item.ctl.redirect = 1'b1;
                n_item.ctl.target   = (a + imm64) & ~64'd1;
            end
            F_BEQ, F_BNE, F_BLT, F_BGE, F_BLTU, F_BGEU: begin
                n_item.ctl.rd_write = 1'b0;
                case (t_func'(i_func))
                    F_BEQ:   n_item.ctl.redirect = (a == b);
                    F_BNE:   n_item.ctl.redirect = (a != b);
                    F_BLT:   n_item.ctl.redirect = ($signed(a) < $signed(b));
                    F_BGE:   n_item.ctl.redirect = !($signed(a) < $signed(b));
                    F_BLTU:  n_item.ctl.redirect = (a < b);
                    default: n_item.ctl.redirect = (a >= b);
                endcase
                n_item.ctl.target = n_item.ctl.redirect ? pc_imm : '0;
            end
            F_ADDI:  n_item.aux = a + imm64;
            F_SLTI:  n_item.aux = {63'b0, $signed(a) < $signed(imm64)};
            F_SLTIU: n_item.aux = {63'b0, a < imm64};
            F_XORI:  n_item.aux = a ^ imm64;
            F_ORI:   n_item.aux = a | imm64;
            F_ANDI:  n_item.aux = a & imm64;
            F_SLLI:  n_item.aux = a << sh_i;
            F_SRLI:  n_item.aux = a >> sh_i;
            F_SRAI:  n_item.aux = $signed(a) >>> sh_i;
            F_ADD:   n_item.aux = a + b;
            F_SUB:   n_item.aux = a - b;
            F_SLL:   n_item.aux = a << sh_r;
            F_SLT:   n_item.aux = {63'b0, $signed(a) < $signed(b)};
            F_SLTU:  n_item.aux = {63'b0, a < b};
            F_XOR:   n_item.aux = a ^ b;
            F_SRL:   n_item.aux = a >> sh_r;
            F_SRA:   n_item.aux = $signed(a) >>> sh_r;
            F_OR:    n_item.aux = a | b;
            F_AND:   n_item.aux = a & b;
            F_ADDIW: n_item.aux = sx32(a + imm64);
            F_SLLIW: n_item.aux = sx32({32'b0, a[31:0] << shw_i});
            F_SRLIW: n_item.aux = sx32({32'b0, a[31:0] >> shw_i});
            F_SRAIW: begin
                wsra       = $signed(a[31:0]) >>> shw_i;
                n_item.aux = sx32({32'b0, wsra});
            end
            F_ADDW:  n_item.aux = sx32(a + b);
            F_SUBW:  n_item.aux = sx32(a - b);
            F_SLLW:  n_item.aux = sx32({32'b0, a[31:0] << shw_r});
            F_SRLW:  n_item.aux = sx32({32'b0, a[31:0] >> shw_r});
            F_SRAW: begin
                wsra       = $signed(a[31:0]) >>> shw_r;
                n_item.aux = sx32({32'b0, wsra});
            end
            F_MUL:   n_item.ctl.kind = K_MUL;
            F_MULW:  n_item.ctl.kind = K_MULW;
            F_MULH: begin
                n_item.ctl.kind = K_MULH;
                n_item.aux = (a[63] ? b : '0) + (b[63] ? a : '0);
            end
            F_MULHSU: begin
                n_item.ctl.kind = K_MULH;
                n_item.aux = a[63] ? b : '0;
            end
            F_MULHU: n_item.ctl.kind = K_MULH;
            F_DIV:   begin d_op = 1'b1; d_sgn = 1'b1; end
            F_DIVU:  d_op = 1'b1;
            F_REM:   begin d_op = 1'b1; d_sgn = 1'b1; d_rem = 1'b1; end
            F_REMU:  begin d_op = 1'b1; d_rem = 1'b1; end
            F_DIVW:  begin d_op = 1'b1; d_sgn = 1'b1; d_word = 1'b1; end
            F_DIVUW: begin d_op = 1'b1; d_word = 1'b1; end
            F_REMW:  begin d_op = 1'b1; d_sgn = 1'b1; d_word = 1'b1; d_rem = 1'b1; end
            F_REMUW: begin d_op = 1'b1; d_word = 1'b1; d_rem = 1'b1; end
            default: n_item.ctl.rd_write = 1'b0;
        endcase

        // divide set-up: magnitudes in, sign fixed up at the finish stage
        if (d_word) begin
            sa = d_sgn ? sx32(a) : {32'b0, a[31:0]};
            sb = d_sgn ? sx32(b) : {32'b0, b[31:0]};
        end else begin
            sa = a;
            sb = b;
        end
        na = d_sgn && sa[63];
        nb = d_sgn && sb[63];
        dz = d_word ? (b[31:0] == 32'b0) : (b == '0);
        if (d_op) begin
            if (dz) begin
                // divide by zero resolved here; the cells pass it through untouched
                n_item.ctl.kind = K_ALU;
                n_item.aux      = d_rem ? (d_word ? sx32(a) : a) : '1;
            end else begin
                n_item.ctl.kind = d_rem ? K_DIVR : K_DIVQ;
                n_item.ctl.word = d_word;
                n_item.ctl.neg  = d_rem ? na : (na ^ nb);
                n_item.quo      = na ? (-sa) : sa;
                n_item.dvs      = nb ? (-sb) : sb;
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/rvex_mulsum.sv =====
// Sums the four partial products into the full 128-bit product.
module rvex_mulsum
    import rvex_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_front  i_item,
    input  logic    i_ready,
    output logic    o_ready,
    output logic    o_valid,
    output t_cell   o_item
);

    logic              r_valid;
    t_cell             r_item;
    t_cell             n_item;
    logic [2*XLEN-1:0] prod;

    assign prod = {i_item.p11, i_item.p00}
                + {32'b0, i_item.p01, 32'b0}
                + {32'b0, i_item.p10, 32'b0};

    always_comb begin
        n_item.ctl = i_item.ctl;
        n_item.aux = i_item.aux;
        n_item.dvs = i_item.dvs;
        if (i_item.ctl.kind == K_MUL || i_item.ctl.kind == K_MULW
            || i_item.ctl.kind == K_MULH) begin
            n_item.rem = prod[2*XLEN-1:XLEN];
            n_item.quo = prod[XLEN-1:0];
        end else begin
            n_item.rem = '0;
            n_item.quo = i_item.quo;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/rvex_div_cell.sv =====
// One restoring-division step: one quotient bit per cell.
module rvex_div_cell
    import rvex_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_cell  i_item,
    input  logic   i_ready,
    output logic   o_ready,
    output logic   o_valid,
    output t_cell  o_item
);

    logic            r_valid;
    t_cell           r_item;
    t_cell           n_item;
    logic [XLEN+1:0] diff;
    logic [XLEN:0]   shifted;

    assign shifted = {i_item.rem, i_item.quo[XLEN-1]};
    assign diff    = {1'b0, shifted} - {2'b0, i_item.dvs};

    always_comb begin
        n_item = i_item;
        if (i_item.ctl.kind == K_DIVQ || i_item.ctl.kind == K_DIVR) begin
            n_item.quo = {i_item.quo[XLEN-2:0], !diff[XLEN+1]};
            n_item.rem = diff[XLEN+1] ? shifted[XLEN-1:0] : diff[XLEN-1:0];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/rvex_finish.sv =====
// Result select, sign fix-up and output register.
module rvex_finish
    import rvex_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_cell            i_item,
    input  logic             i_stall,
    output logic             o_ready,
    output logic             o_valid,
    output logic [XLEN-1:0]  o_rd_value,
    output logic             o_rd_write,
    output logic [4:0]       o_dest_out,
    output logic             o_redirect,
    output logic [XLEN-1:0]  o_redirect_target
);

    logic            r_valid;
    logic [XLEN-1:0] r_rd_value;
    t_ctl            r_ctl;
    logic [XLEN-1:0] n_rd_value;
    logic [XLEN-1:0] dv;

    assign dv = (i_item.ctl.kind == K_DIVR) ? i_item.rem : i_item.quo;

    always_comb begin
        logic [XLEN-1:0] sd;
        sd = i_item.ctl.neg ? (-dv) : dv;
        case (i_item.ctl.kind)
            K_MUL:          n_rd_value = i_item.quo;
            K_MULW:         n_rd_value = sx32(i_item.quo);
            K_MULH:         n_rd_value = i_item.rem - i_item.aux;
            K_DIVQ, K_DIVR: n_rd_value = i_item.ctl.word ? sx32(sd) : sd;
            default:        n_rd_value = i_item.aux;
        endcase
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_rd_value <= n_rd_value;
            r_ctl      <= i_item.ctl;
        end
    end

    assign o_valid           = r_valid;
    assign o_rd_value        = r_rd_value;
    assign o_rd_write        = r_ctl.rd_write;
    assign o_dest_out        = r_ctl.dest;
    assign o_redirect        = r_ctl.redirect;
    assign o_redirect_target = r_ctl.target;

endmodule
